// File: hw/rtl/lert_pkg.sv
// Shared types and constants for the lane edge row tracker.
// No dependencies; used by every module under hw/rtl.
package lert_pkg;

  localparam int ColBits  = 10;
  localparam int WidthBits = 11;
  localparam logic [WidthBits-1:0] WidthLimit = 11'd1024;
  localparam logic [ColBits-1:0]   ColMax     = 10'd1023;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_LEFT_INIT   = 2'd1,
    CFG_RIGHT_INIT  = 2'd2,
    CFG_OFFSET      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WidthBits-1:0] image_width;
    logic [ColBits-1:0]   left_start_init;
    logic [ColBits-1:0]   right_start_init;
    logic [ColBits-1:0]   track_offset;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         pixel;
    logic [ColBits-1:0] row_index;
    logic               row_last;
    logic               frame_first;
  } pix_t;

  typedef struct packed {
    logic               right_found;
    logic [ColBits-1:0] right_column;
    logic               left_found;
    logic [ColBits-1:0] left_column;
    logic [ColBits-1:0] out_row;
  } res_t;

endpackage

// File: hw/rtl/lert_row_scan.sv
// Per-row boundary search state and its single-pass update logic.
// Depends on lert_pkg.
module lert_row_scan (
  input  logic            clk,
  input  logic            rst,
  input  lert_pkg::cfg_t  cfg,
  input  logic            step,
  input  lert_pkg::pix_t  item,
  output lert_pkg::res_t  result
);

  logic [9:0] column_count, column_count_next;
  logic       row_overrun, row_overrun_next;
  logic [9:0] left_start, left_start_next;
  logic [9:0] right_start, right_start_next;
  logic [9:0] left_best, left_best_next;
  logic       left_hit, left_hit_next;
  logic [9:0] right_best, right_best_next;
  logic       right_hit, right_hit_next;

  logic [9:0]  last_col;
  logic [9:0]  ls_cur, rs_cur, ls_c, rs_c, cnt;
  logic        ovr, lh, rh, mark, ltake, rtake;
  logic [9:0]  lc, rc, nr;
  logic [10:0] nl_sum;

  // Effective last column: zero width acts as one, oversize as the limit
  always_comb begin
    if (cfg.image_width == '0) begin
      last_col = '0;
    end else if (cfg.image_width > lert_pkg::WidthLimit) begin
      last_col = lert_pkg::ColMax;
    end else begin
      last_col = 10'(cfg.image_width - 11'd1);
    end
  end

  always_comb begin
    ls_cur = item.frame_first ? cfg.left_start_init  : left_start;
    rs_cur = item.frame_first ? cfg.right_start_init : right_start;
    cnt    = item.frame_first ? '0   : column_count;
    ovr    = item.frame_first ? 1'b0 : row_overrun;
    lh     = item.frame_first ? 1'b0 : left_hit;
    rh     = item.frame_first ? 1'b0 : right_hit;

    ls_c = (ls_cur > last_col) ? last_col : ls_cur;
    rs_c = (rs_cur > last_col) ? last_col : rs_cur;

    mark  = !ovr && (item.pixel != '0) && (cnt <= last_col);
    ltake = mark && (cnt <= ls_c);
    rtake = mark && (cnt >= rs_c) && !rh;

    left_hit_next   = lh | ltake;
    left_best_next  = ltake ? cnt : left_best;
    right_hit_next  = rh | rtake;
    right_best_next = rtake ? cnt : right_best;

    // Hold the count at the top column once a row overruns
    column_count_next = cnt;
    row_overrun_next  = ovr;
    if (!ovr) begin
      if (cnt == lert_pkg::ColMax) begin
        row_overrun_next = 1'b1;
      end else begin
        column_count_next = cnt + 10'd1;
      end
    end

    lc = left_hit_next  ? left_best_next  : '0;
    rc = right_hit_next ? right_best_next : last_col;
    nl_sum = {1'b0, lc} + {1'b0, cfg.track_offset};
    nr = (rc > cfg.track_offset) ? (rc - cfg.track_offset) : '0;

    result.out_row      = item.row_index;
    result.left_column  = lc;
    result.left_found   = left_hit_next;
    result.right_column = rc;
    result.right_found  = right_hit_next;

    left_start_next  = ls_cur;
    right_start_next = rs_cur;
    if (item.row_last) begin
      left_start_next   = (nl_sum > {1'b0, last_col}) ? last_col : nl_sum[9:0];
      right_start_next  = (nr > last_col) ? last_col : nr;
      column_count_next = '0;
      row_overrun_next  = 1'b0;
      left_hit_next     = 1'b0;
      right_hit_next    = 1'b0;
      left_best_next    = '0;
      right_best_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_overrun  <= 1'b0;
      left_start   <= 10'd0;
      right_start  <= 10'd639;
      left_best    <= '0;
      left_hit     <= 1'b0;
      right_best   <= '0;
      right_hit    <= 1'b0;
    end else if (step) begin
      column_count <= column_count_next;
      row_overrun  <= row_overrun_next;
      left_start   <= left_start_next;
      right_start  <= right_start_next;
      left_best    <= left_best_next;
      left_hit     <= left_hit_next;
      right_best   <= right_best_next;
      right_hit    <= right_hit_next;
    end
  end

endmodule

// File: hw/rtl/lert_out_reg.sv
// Result register on the master side of the tracker.
// Depends on lert_pkg.
module lert_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  lert_pkg::res_t  result,
  output logic            busy,
  output logic            tvalid,
  input  logic            tready,
  output lert_pkg::res_t  data
);

  logic valid;

  assign tvalid = valid;
  // Slot is unavailable only while a result waits and is not taken
  assign busy   = valid && !tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

// File: hw/rtl/lane_edge_row_tracker_top.sv
// Lane edge row tracker: a row_last transaction passes the input register, then the output register.
// Throughput is one pixel per cycle; the input register stalls only while a finished
// result is held in the output register and a further row_last pixel waits behind it.
// Synchronous active-high reset empties both registers, loads register defaults
// (width 640, left start 0, right start 639, offset 63) and clears the row state.
// Depends on lert_pkg, lert_row_scan and lert_out_reg.
module lane_edge_row_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel[7:0], row_index[17:8], zero pad
  input  logic        s_axis_tlast,   // row_last
  input  logic        s_axis_tuser,   // frame_first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_row, left_column, left_found,
                                      // right_column, right_found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  lert_pkg::cfg_t cfg;
  lert_pkg::pix_t s1_item;
  lert_pkg::res_t scan_result, out_data;
  logic s1_valid, step, out_busy, out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width      <= 11'd640;
      cfg.left_start_init  <= 10'd0;
      cfg.right_start_init <= 10'd639;
      cfg.track_offset     <= 10'd63;
    end else if (cfg_valid && cfg_ready) begin
      case (lert_pkg::cfg_reg_t'(cfg_index))
        lert_pkg::CFG_IMAGE_WIDTH: cfg.image_width      <= cfg_data;
        lert_pkg::CFG_LEFT_INIT:   cfg.left_start_init  <= cfg_data[9:0];
        lert_pkg::CFG_RIGHT_INIT:  cfg.right_start_init <= cfg_data[9:0];
        lert_pkg::CFG_OFFSET:      cfg.track_offset     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Advance the held pixel unless its result would overwrite a waiting one
  assign step          = s1_valid && !(s1_item.row_last && out_busy);
  assign s_axis_tready = !s1_valid || step;
  assign out_load      = step && s1_item.row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item.pixel       <= s_axis_tdata[7:0];
      s1_item.row_index   <= s_axis_tdata[17:8];
      s1_item.row_last    <= s_axis_tlast;
      s1_item.frame_first <= s_axis_tuser;
    end
  end

  lert_row_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (s1_item),
    .result (scan_result)
  );

  lert_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .result (scan_result),
    .busy   (out_busy),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .data   (out_data)
  );

  assign m_axis_tdata = out_data;

  a_result_from_row_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(step && s1_item.row_last))
    else $error("result appeared without a row_last pixel");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_item.row_last && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while a row result is blocked");

  a_plain_pixel_no_result: assert property (@(posedge clk) disable iff (rst)
    (step && !s1_item.row_last && !(m_axis_tvalid && !m_axis_tready)) |=> !m_axis_tvalid)
    else $error("result produced by a pixel that does not end a row");

endmodule

// File: verif/lane_edge_row_tracker_top_tb.sv
// Self-checking testbench for lane_edge_row_tracker_top: pixel rows in, boundary results out.
// Predicts each row result from its own copy of the tracking state and compares per field.
// Depends on lert_pkg and the lane_edge_row_tracker_top RTL.
module lane_edge_row_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RunLimit    = 400000;
  localparam int SettleTicks = 4;
  localparam int DrainTicks  = 10;
  localparam int RandomItems = 480;

  typedef struct packed {
    lert_pkg::cfg_reg_t idx;
    logic [10:0]        val;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  lane_edge_row_tracker_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lert_pkg::pix_t pixel_queue[$];
  reg_write_t     reg_queue[$];
  lert_pkg::res_t expected_rows[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  queued_items = 0;
  bit  src_gaps = 1'b0;
  bit  sink_gaps = 1'b0;
  int  sink_hold_len = 0;
  int  sink_hold_req = 0;
  int  sink_hold_seen = 0;
  int  src_wait = 0;
  int  sink_wait = 0;

  // Tracking state of the predictor
  lert_pkg::cfg_t model_cfg;
  int   col_count;
  bit   overrun;
  int   left_start, right_start, left_best, right_best;
  bit   left_hit, right_hit;

  lert_pkg::pix_t drive_pix;
  lert_pkg::pix_t seen_pix;
  lert_pkg::res_t seen_res, got_res;
  bit   seen_emit;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic int min_col(input int c, input int lim);
    return (c > lim) ? lim : c;
  endfunction

  function automatic int active_width();
    if (model_cfg.image_width == 0) return 1;
    if (model_cfg.image_width > lert_pkg::WidthLimit) return int'(lert_pkg::WidthLimit);
    return int'(model_cfg.image_width);
  endfunction

  task automatic track_pixel(input lert_pkg::pix_t px, output bit emits,
                             output lert_pkg::res_t row_res);
    int w, lastcol, lc, rc, nl, nr;
    w = active_width();
    lastcol = w - 1;
    emits = 1'b0;
    row_res = '0;
    // Frame start reloads the starts before the pixel counts as column 0
    if (px.frame_first) begin
      left_start  = model_cfg.left_start_init;
      right_start = model_cfg.right_start_init;
      col_count   = 0;
      overrun     = 1'b0;
      left_hit    = 1'b0;
      right_hit   = 1'b0;
    end
    if (!overrun) begin
      if (col_count < w && px.pixel != 0) begin
        if (col_count <= min_col(left_start, lastcol)) begin
          left_best = col_count;
          left_hit  = 1'b1;
        end
        if (col_count >= min_col(right_start, lastcol) && !right_hit) begin
          right_best = col_count;
          right_hit  = 1'b1;
        end
      end
      if (col_count >= 1023) overrun = 1'b1;
      else col_count++;
    end
    if (px.row_last) begin
      lc = left_hit ? left_best : 0;
      rc = right_hit ? right_best : lastcol;
      nl = min_col(lc + model_cfg.track_offset, lastcol);
      nr = (rc > model_cfg.track_offset) ? rc - model_cfg.track_offset : 0;
      emits = 1'b1;
      row_res.out_row      = px.row_index;
      row_res.left_column  = lc[9:0];
      row_res.left_found   = left_hit;
      row_res.right_column = rc[9:0];
      row_res.right_found  = right_hit;
      left_start  = nl;
      right_start = min_col(nr, lastcol);
      col_count   = 0;
      overrun     = 1'b0;
      left_hit    = 1'b0;
      right_hit   = 1'b0;
      left_best   = 0;
      right_best  = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [9:0] exp_v, input logic [9:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Pixel driver: hold a transaction until taken, then sometimes idle for a random gap
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        drive_pix = pixel_queue.pop_front();
        s_axis_tdata  <= {6'd0, drive_pix.row_index, drive_pix.pixel};
        s_axis_tlast  <= drive_pix.row_last;
        s_axis_tuser  <= drive_pix.frame_first;
        s_axis_tvalid <= 1'b1;
        if (src_gaps && $urandom_range(0, 99) < 20) src_wait = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_queue.size() != 0) begin
        cfg_index <= reg_queue[0].idx;
        cfg_data  <= reg_queue[0].val;
        cfg_valid <= 1'b1;
        void'(reg_queue.pop_front());
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (sink_hold_req != sink_hold_seen) begin
        sink_hold_seen = sink_hold_req;
        sink_wait = sink_hold_len;
      end
      if (sink_wait > 0) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else if (sink_gaps && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        sink_wait = pick_gap() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results, track register writes, predict on every pixel taken
  always @(posedge clk) begin
    if (rst) begin
      model_cfg.image_width      = 11'd640;
      model_cfg.left_start_init  = 10'd0;
      model_cfg.right_start_init = 10'd639;
      model_cfg.track_offset     = 10'd63;
      col_count   = 0;
      overrun     = 1'b0;
      left_start  = 0;
      right_start = 639;
      left_best   = 0;
      right_best  = 0;
      left_hit    = 1'b0;
      right_hit   = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = lert_pkg::res_t'(m_axis_tdata);
        if (expected_rows.size() == 0) begin
          $error("unexpected result transaction: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          seen_res = expected_rows.pop_front();
          check_field("out_row", seen_res.out_row, got_res.out_row);
          check_field("left_column", seen_res.left_column, got_res.left_column);
          check_field("left_found", 10'(seen_res.left_found), 10'(got_res.left_found));
          check_field("right_column", seen_res.right_column, got_res.right_column);
          check_field("right_found", 10'(seen_res.right_found), 10'(got_res.right_found));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (lert_pkg::cfg_reg_t'(cfg_index))
          lert_pkg::CFG_IMAGE_WIDTH: model_cfg.image_width      = cfg_data;
          lert_pkg::CFG_LEFT_INIT:   model_cfg.left_start_init  = cfg_data[9:0];
          lert_pkg::CFG_RIGHT_INIT:  model_cfg.right_start_init = cfg_data[9:0];
          lert_pkg::CFG_OFFSET:      model_cfg.track_offset     = cfg_data[9:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_pix.pixel       = s_axis_tdata[7:0];
        seen_pix.row_index   = s_axis_tdata[17:8];
        seen_pix.row_last    = s_axis_tlast;
        seen_pix.frame_first = s_axis_tuser;
        track_pixel(seen_pix, seen_emit, seen_res);
        if (seen_emit) expected_rows = {expected_rows, seen_res};
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RunLimit) begin
      $display("lane_edge_row_tracker_top_tb failed");
      $finish;
    end
  end

  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (pixel_queue.size() != 0 || s_axis_tvalid || reg_queue.size() != 0 || cfg_valid
           || expected_rows.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic queue_reg(input lert_pkg::cfg_reg_t idx, input int val);
    reg_write_t wr;
    wr.idx = idx;
    wr.val = 11'(val);
    reg_queue = {reg_queue, wr};
  endtask

  task automatic load_regs(input int w, input int li, input int ri, input int off);
    wait_idle(SettleTicks);
    queue_reg(lert_pkg::CFG_IMAGE_WIDTH, w);
    queue_reg(lert_pkg::CFG_LEFT_INIT, li);
    queue_reg(lert_pkg::CFG_RIGHT_INIT, ri);
    queue_reg(lert_pkg::CFG_OFFSET, off);
    wait_idle(0);
  endtask

  task automatic push_pixel(input int pixel, input int row, input bit eol, input bit sof);
    lert_pkg::pix_t px;
    px.pixel       = 8'(pixel);
    px.row_index   = 10'(row);
    px.row_last    = eol;
    px.frame_first = sof;
    pixel_queue = {pixel_queue, px};
    queued_items++;
  endtask

  // Lane marks near two drifting columns plus sparse noise; sometimes a stray frame start or row index
  task automatic queue_row(input int row, input int len, input bit sof, input int lane_l,
                           input int lane_r);
    int  restart, pix, ridx;
    bit  near;
    restart = ($urandom_range(0, 99) < 3) ? $urandom_range(1, len) : -1;
    for (int c = 0; c < len; c++) begin
      near = (c >= lane_l - 1 && c <= lane_l + 1) || (c >= lane_r - 1 && c <= lane_r + 1);
      if (near) pix = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 255) : 0;
      else pix = ($urandom_range(0, 99) < 4) ? $urandom_range(1, 255) : 0;
      ridx = ($urandom_range(0, 99) < 95 || c == len - 1) ? row : $urandom_range(0, 1023);
      push_pixel(pix, ridx, c == len - 1, (c == 0 && sof) || c == restart);
    end
  endtask

  initial begin
    int w, li, ri, off, start, nrows, row, len, lane_l, lane_r, random_items;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty row, then a short row
    push_pixel(8'h00, 1023, 1'b1, 1'b1);
    push_pixel(8'hFF, 0, 1'b0, 1'b1);
    push_pixel(8'h00, 0, 1'b0, 1'b0);
    push_pixel(8'h01, 0, 1'b1, 1'b0);

    // Right start left of left start; row longer than width; frame start mid-row
    load_regs(4, 2, 1, 0);
    push_pixel(8'h80, 5, 1'b0, 1'b1);
    push_pixel(8'h7F, 5, 1'b0, 1'b0);
    push_pixel(8'h00, 5, 1'b0, 1'b0);
    push_pixel(8'h01, 5, 1'b1, 1'b0);
    for (int c = 0; c < 6; c++) push_pixel(c >= 4 ? 8'hFF : 8'h00, 6, c == 5, 1'b0);
    push_pixel(8'h10, 7, 1'b0, 1'b0);
    push_pixel(8'h20, 8, 1'b0, 1'b1);
    push_pixel(8'h00, 8, 1'b1, 1'b0);

    // Width zero acts as one column
    load_regs(0, 1023, 1023, 1023);
    push_pixel(8'h05, 9, 1'b0, 1'b1);
    push_pixel(8'h05, 9, 1'b0, 1'b0);
    push_pixel(8'h05, 9, 1'b1, 1'b0);
    push_pixel(8'h00, 10, 1'b1, 1'b0);

    // Width above the limit; init data with the spare top bit set
    load_regs(2047, 11'h7FF, 11'h400, 0);
    push_pixel(8'h01, 11, 1'b0, 1'b1);
    push_pixel(8'h00, 11, 1'b1, 1'b0);
    push_pixel(8'h00, 12, 1'b0, 1'b0);
    push_pixel(8'hAA, 12, 1'b1, 1'b0);

    // Full width and a row past the column counter limit
    load_regs(1024, 1023, 1000, 5);
    for (int c = 0; c < 1030; c++)
      push_pixel((c == 0 || c == 1010 || c == 1023 || c == 1025 || c == 1029) ? 8'h40 : 8'h00,
                 100, c == 1029, c == 0);
    for (int c = 0; c < 20; c++) push_pixel(c == 3 ? 8'h02 : 8'h00, 101, c == 19, 1'b0);

    // Back-pressure: one-pixel rows against a long receiver hold-off
    load_regs(2, 0, 1, 0);
    src_gaps = 1'b0;
    sink_hold_len = 300;
    sink_hold_req++;
    for (int i = 0; i < 60; i++) push_pixel($urandom_range(0, 3), i, 1'b1, i == 0);
    wait_idle(0);

    random_items = 0;
    while (random_items < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       w = 2;
        1, 2:    w = $urandom_range(25, 64);
        default: w = $urandom_range(2, 24);
      endcase
      li  = (($urandom_range(0, 1) == 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 1023))
            | (($urandom_range(0, 3) == 0) ? 11'h400 : 0);
      ri  = (($urandom_range(0, 1) == 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 1023))
            | (($urandom_range(0, 3) == 0) ? 11'h400 : 0);
      case ($urandom_range(0, 9))
        0:       off = ($urandom_range(0, 1) == 0) ? 1023 : $urandom_range(0, 1023);
        1, 2:    off = $urandom_range(0, w);
        default: off = $urandom_range(0, 4);
      endcase
      load_regs(w, li, ri, off);
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      start = queued_items;
      while (queued_items - start < 80) begin
        nrows  = $urandom_range(1, 6);
        row    = $urandom_range(0, 1023);
        lane_l = $urandom_range(0, w - 1);
        lane_r = $urandom_range(0, w - 1);
        for (int r = 0; r < nrows; r++) begin
          len = ($urandom_range(0, 99) < 85) ? w : $urandom_range(1, w + 4);
          queue_row(row, len, r == 0 && $urandom_range(0, 9) != 0, lane_l, lane_r);
          row    = (row + $urandom_range(1, 8)) % 1024;
          lane_l = min_col(lane_l + int'($urandom_range(0, 4)) - 2, w - 1);
          lane_r = min_col(lane_r + int'($urandom_range(0, 4)) - 2, w - 1);
          if (lane_l < 0) lane_l = 0;
          if (lane_r < 0) lane_r = 0;
        end
      end
      random_items += queued_items - start;
    end

    wait_idle(DrainTicks);
    if (fail_count == 0) begin
      $display("lane_edge_row_tracker_top_tb passed");
    end else begin
      $display("lane_edge_row_tracker_top_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lert_pkg.sv
hw/rtl/lert_row_scan.sv
hw/rtl/lert_out_reg.sv
hw/rtl/lane_edge_row_tracker_top.sv
verif/lane_edge_row_tracker_top_tb.sv
